[sv/mtep_pkg.sv]
package mtep_pkg;

    typedef enum logic [2:0] {
        PH_DELAY,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_LENGTH,
        PH_META,
        PH_DONE
    } phase_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_META   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [7:0] STATUS_FLAG     = 8'h80;
    localparam logic [7:0] DATA_MASK       = 8'h7F;
    localparam logic [7:0] ST_SYSTEM       = 8'hF0;
    localparam logic [7:0] ST_SONG_POS     = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
    localparam logic [7:0] ST_SYSEX_ESC    = 8'hF7;
    localparam logic [7:0] ST_META         = 8'hFF;
    localparam logic [7:0] ST_PROG_CHANGE  = 8'hC0;
    localparam logic [7:0] ST_PITCH_BEND   = 8'hE0;
    localparam logic [7:0] META_END_TRACK  = 8'h2F;

    typedef struct packed {
        logic [7:0] track_byte;
        logic       new_track;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delay;
        logic [7:0]  status;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [31:0] meta_length;
        logic [7:0]  meta_byte;
        logic        meta_last;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  running_status;
        logic [7:0]  current_status;
        logic [31:0] delay_accum;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] length_accum;
        logic [31:0] meta_remaining;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_DELAY,
        running_status: 8'h00,
        current_status: 8'h00,
        delay_accum:    32'h0,
        first_data:     8'h00,
        second_data:    8'h00,
        length_accum:   32'h0,
        meta_remaining: 32'h0
    };

    function automatic logic wants_first(input logic [7:0] st);
        return (st < ST_SYSTEM) || (st == ST_SONG_POS) || (st == ST_SONG_SEL)
            || (st == ST_META);
    endfunction

    function automatic logic wants_second(input logic [7:0] st);
        return (st < ST_PROG_CHANGE) || ((st >= ST_PITCH_BEND) && (st < ST_SYSTEM))
            || (st == ST_SONG_POS);
    endfunction

    function automatic logic has_length(input logic [7:0] st);
        return (st == ST_SYSTEM) || (st == ST_SYSEX_ESC) || (st == ST_META);
    endfunction

endpackage

[sv/mtep_step.sv]
module mtep_step (
    input  mtep_pkg::parse_state_t state_cur,
    input  mtep_pkg::in_item_t     item,
    output mtep_pkg::parse_state_t state_next,
    output logic                   res_valid,
    output mtep_pkg::out_item_t    res
);

    always_comb begin
        mtep_pkg::parse_state_t s;
        logic [7:0]             b;
        logic                   do_after;

        s         = item.new_track ? mtep_pkg::STATE_RESET : state_cur;
        b         = item.track_byte;
        do_after  = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        unique case (s.phase)
            mtep_pkg::PH_DELAY: begin
                s.delay_accum = {s.delay_accum[24:0], b[6:0]};
                if ((b & mtep_pkg::STATUS_FLAG) == 8'h00) begin
                    s.phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                s.first_data  = 8'h00;
                s.second_data = 8'h00;
                if ((b & mtep_pkg::STATUS_FLAG) != 8'h00) begin
                    s.current_status = b;
                    if (b < mtep_pkg::ST_SYSTEM) begin
                        s.running_status = b;
                    end
                    if (mtep_pkg::wants_first(b)) begin
                        s.phase = mtep_pkg::PH_DATA1;
                    end else begin
                        do_after = 1'b1;
                    end
                end else begin
                    s.current_status = s.running_status;
                    s.first_data     = b;
                    if (mtep_pkg::wants_second(s.current_status)) begin
                        s.phase = mtep_pkg::PH_DATA2;
                    end else begin
                        do_after = 1'b1;
                    end
                end
            end
            mtep_pkg::PH_DATA1: begin
                s.first_data = b;
                if ((s.current_status == mtep_pkg::ST_META)
                        && (b == mtep_pkg::META_END_TRACK)) begin
                    res_valid        = 1'b1;
                    res.kind         = mtep_pkg::KIND_END;
                    res.delay        = s.delay_accum;
                    res.status       = mtep_pkg::ST_META;
                    res.data_first   = mtep_pkg::META_END_TRACK;
                    s.current_status = 8'h00;
                    s.delay_accum    = 32'h0;
                    s.first_data     = 8'h00;
                    s.second_data    = 8'h00;
                    s.length_accum   = 32'h0;
                    s.phase          = mtep_pkg::PH_DONE;
                end else if (mtep_pkg::wants_second(s.current_status)) begin
                    s.phase = mtep_pkg::PH_DATA2;
                end else begin
                    do_after = 1'b1;
                end
            end
            mtep_pkg::PH_DATA2: begin
                s.second_data = b;
                do_after      = 1'b1;
            end
            mtep_pkg::PH_LENGTH: begin
                s.length_accum = {s.length_accum[24:0], b[6:0]};
                if ((b & mtep_pkg::STATUS_FLAG) == 8'h00) begin
                    res_valid        = 1'b1;
                    res.kind         = mtep_pkg::KIND_HEADER;
                    res.delay        = s.delay_accum;
                    res.status       = s.current_status;
                    res.data_first   = s.first_data;
                    res.data_second  = s.second_data;
                    res.meta_length  = s.length_accum;
                    s.meta_remaining = s.length_accum;
                    s.phase          = (s.length_accum != 32'h0) ? mtep_pkg::PH_META
                                                                 : mtep_pkg::PH_DELAY;
                    s.current_status = 8'h00;
                    s.delay_accum    = 32'h0;
                    s.first_data     = 8'h00;
                    s.second_data    = 8'h00;
                    s.length_accum   = 32'h0;
                end
            end
            mtep_pkg::PH_META: begin
                res_valid        = 1'b1;
                res.kind         = mtep_pkg::KIND_META;
                res.meta_byte    = b;
                res.meta_last    = (s.meta_remaining == 32'h1);
                s.meta_remaining = s.meta_remaining - 32'h1;
                if (s.meta_remaining == 32'h0) begin
                    s.phase = mtep_pkg::PH_DELAY;
                end
            end
            default: begin
            end
        endcase

        if (do_after) begin
            if (mtep_pkg::has_length(s.current_status)) begin
                s.length_accum = 32'h0;
                s.phase        = mtep_pkg::PH_LENGTH;
            end else begin
                res_valid        = 1'b1;
                res.kind         = mtep_pkg::KIND_HEADER;
                res.delay        = s.delay_accum;
                res.status       = s.current_status;
                res.data_first   = s.first_data;
                res.data_second  = s.second_data;
                s.current_status = 8'h00;
                s.delay_accum    = 32'h0;
                s.first_data     = 8'h00;
                s.second_data    = 8'h00;
                s.length_accum   = 32'h0;
                s.phase          = mtep_pkg::PH_DELAY;
            end
        end

        state_next = s;
    end

endmodule

[sv/midi_track_event_parser.sv]
// Parses a standard MIDI file track one byte per transaction and produces at most one
// result per byte: an event header (delta time, effective status with running status,
// data bytes, metadata length), one result per SysEx or meta payload byte, and an end
// of track result after meta type 0x2F, after which bytes are dropped until new_track.
// A byte is taken every cycle when the output does not stall; its result, if any, goes
// through the input register, then the combinational parser update, into the output
// register. Back-pressure stalls the output register, and the input register once full.
module midi_track_event_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtep_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mtep_pkg::out_item_t m_item
);

    logic                   in_valid_reg;
    mtep_pkg::in_item_t     in_item_reg;
    mtep_pkg::parse_state_t state_reg;
    mtep_pkg::parse_state_t state_next;
    logic                   out_valid_reg;
    mtep_pkg::out_item_t    out_item_reg;
    logic                   res_valid;
    mtep_pkg::out_item_t    res;
    logic                   advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    mtep_step u_step (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= mtep_pkg::STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg && res_valid;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && in_valid_reg && res_valid) begin
            out_item_reg <= res;
        end
    end

    a_end_enters_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && res_valid && (res.kind == mtep_pkg::KIND_END))
        |=> (state_reg.phase == mtep_pkg::PH_DONE))
        else $error("End of track result did not stop the parser.");

    a_done_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (state_reg.phase == mtep_pkg::PH_DONE) && !in_item_reg.new_track)
        |-> !res_valid)
        else $error("A result was produced after end of track.");

    a_last_meta_ends_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && res_valid && (res.kind == mtep_pkg::KIND_META)
            && res.meta_last)
        |=> (state_reg.phase == mtep_pkg::PH_DELAY))
        else $error("Last metadata byte did not return the parser to the delta time.");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("Input stalled while the output register was empty.");

endmodule

[verif/midi_track_event_parser_tb.sv]
module midi_track_event_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 2000;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    localparam mtep_pkg::out_item_t NO_RESULT = '0;

    typedef struct packed {
        logic [7:0]          track_byte;
        logic                new_track;
        logic                hand_checked;
        mtep_pkg::out_item_t hand_result;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 30;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h90, 1'b0, 1'b0, NO_RESULT},
        '{8'h3C, 1'b0, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, 1'b1,
            '{mtep_pkg::KIND_HEADER, 32'd0, 8'h90, 8'h3C, 8'h7F, 32'd0, 8'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h40, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1,
            '{mtep_pkg::KIND_HEADER, 32'd0, 8'h90, 8'h40, 8'h00, 32'd0, 8'h00, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{8'hC0, 1'b0, 1'b0, NO_RESULT},
        '{8'h05, 1'b0, 1'b1,
            '{mtep_pkg::KIND_HEADER, 32'hFFFF_FFFF, 8'hC0, 8'h05, 8'h00, 32'd0, 8'h00,
              1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h03, 1'b0, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, 1'b1,
            '{mtep_pkg::KIND_HEADER, 32'd0, 8'hFF, 8'h03, 8'h00, 32'd2, 8'h00, 1'b0}},
        '{8'h41, 1'b0, 1'b1,
            '{mtep_pkg::KIND_META, 32'd0, 8'h00, 8'h00, 8'h00, 32'd0, 8'h41, 1'b0}},
        '{8'hBE, 1'b0, 1'b1,
            '{mtep_pkg::KIND_META, 32'd0, 8'h00, 8'h00, 8'h00, 32'd0, 8'hBE, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hF0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1,
            '{mtep_pkg::KIND_HEADER, 32'd0, 8'hF0, 8'h00, 8'h00, 32'd0, 8'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h2F, 1'b0, 1'b1,
            '{mtep_pkg::KIND_END, 32'd0, 8'hFF, 8'h2F, 8'h00, 32'd0, 8'h00, 1'b0}},
        '{8'h90, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h10, 1'b0, 1'b0, NO_RESULT},
        '{8'h20, 1'b0, 1'b1,
            '{mtep_pkg::KIND_HEADER, 32'd0, 8'h00, 8'h10, 8'h20, 32'd0, 8'h00, 1'b0}}
    };

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mtep_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mtep_pkg::out_item_t m_item;

    mtep_pkg::out_item_t predicted_events[$];
    mtep_pkg::in_item_t  event_bytes[$];

    mtep_pkg::phase_t parse_phase  = mtep_pkg::PH_DELAY;
    logic [7:0]       running_st   = 8'h00;
    logic [7:0]       event_st     = 8'h00;
    logic [31:0]      delta_ticks  = '0;
    logic [7:0]       msg_data1    = 8'h00;
    logic [7:0]       msg_data2    = 8'h00;
    logic [31:0]      payload_len  = '0;
    logic [31:0]      payload_left = '0;

    int mismatch_count = 0;
    int live_bytes     = 0;
    int idle_cycles    = 0;
    int ready_hold     = 0;
    int calm_left      = 0;

    midi_track_event_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned data_bytes_for(input logic [7:0] st);
        if (st < mtep_pkg::ST_PROG_CHANGE) begin
            return 2;
        end
        if (st < mtep_pkg::ST_PITCH_BEND) begin
            return 1;
        end
        if (st < mtep_pkg::ST_SYSTEM) begin
            return 2;
        end
        case (st)
            mtep_pkg::ST_SONG_POS: return 2;
            mtep_pkg::ST_SONG_SEL, mtep_pkg::ST_META: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic bit takes_length(input logic [7:0] st);
        return (st == mtep_pkg::ST_SYSTEM) || (st == mtep_pkg::ST_SYSEX_ESC)
            || (st == mtep_pkg::ST_META);
    endfunction

    task automatic clear_event_regs();
        event_st    = 8'h00;
        delta_ticks = '0;
        msg_data1   = 8'h00;
        msg_data2   = 8'h00;
        payload_len = '0;
    endtask

    // The data bytes of an event are complete: either a length field follows
    // or the header goes out now.
    task automatic close_data(output bit made, output mtep_pkg::out_item_t res);
        made = 1'b0;
        res  = NO_RESULT;
        if (takes_length(event_st)) begin
            payload_len = '0;
            parse_phase = mtep_pkg::PH_LENGTH;
        end else begin
            res.kind        = mtep_pkg::KIND_HEADER;
            res.delay       = delta_ticks;
            res.status      = event_st;
            res.data_first  = msg_data1;
            res.data_second = msg_data2;
            made = 1'b1;
            clear_event_regs();
            parse_phase = mtep_pkg::PH_DELAY;
        end
    endtask

    task automatic parse_track_byte(input mtep_pkg::in_item_t it, output bit made,
                                    output mtep_pkg::out_item_t res);
        logic [7:0] b;
        b    = it.track_byte;
        made = 1'b0;
        res  = NO_RESULT;
        if (it.new_track) begin
            parse_phase  = mtep_pkg::PH_DELAY;
            running_st   = 8'h00;
            payload_left = '0;
            clear_event_regs();
        end
        case (parse_phase)
            mtep_pkg::PH_DELAY: begin
                delta_ticks = {delta_ticks[24:0], b[6:0]};
                if (!b[7]) begin
                    parse_phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                msg_data1 = 8'h00;
                msg_data2 = 8'h00;
                if (b[7]) begin
                    event_st = b;
                    if (b < mtep_pkg::ST_SYSTEM) begin
                        running_st = b;
                    end
                    if (data_bytes_for(b) != 0) begin
                        parse_phase = mtep_pkg::PH_DATA1;
                    end else begin
                        close_data(made, res);
                    end
                end else begin
                    event_st  = running_st;
                    msg_data1 = b;
                    if (data_bytes_for(event_st) == 2) begin
                        parse_phase = mtep_pkg::PH_DATA2;
                    end else begin
                        close_data(made, res);
                    end
                end
            end
            mtep_pkg::PH_DATA1: begin
                msg_data1 = b;
                if (event_st == mtep_pkg::ST_META && b == mtep_pkg::META_END_TRACK) begin
                    res.kind       = mtep_pkg::KIND_END;
                    res.delay      = delta_ticks;
                    res.status     = mtep_pkg::ST_META;
                    res.data_first = mtep_pkg::META_END_TRACK;
                    made = 1'b1;
                    clear_event_regs();
                    parse_phase = mtep_pkg::PH_DONE;
                end else if (data_bytes_for(event_st) == 2) begin
                    parse_phase = mtep_pkg::PH_DATA2;
                end else begin
                    close_data(made, res);
                end
            end
            mtep_pkg::PH_DATA2: begin
                msg_data2 = b;
                close_data(made, res);
            end
            mtep_pkg::PH_LENGTH: begin
                payload_len = {payload_len[24:0], b[6:0]};
                if (!b[7]) begin
                    res.kind        = mtep_pkg::KIND_HEADER;
                    res.delay       = delta_ticks;
                    res.status      = event_st;
                    res.data_first  = msg_data1;
                    res.data_second = msg_data2;
                    res.meta_length = payload_len;
                    made = 1'b1;
                    payload_left = payload_len;
                    clear_event_regs();
                    parse_phase = (payload_left != 0) ? mtep_pkg::PH_META
                                                      : mtep_pkg::PH_DELAY;
                end
            end
            mtep_pkg::PH_META: begin
                res.kind      = mtep_pkg::KIND_META;
                res.meta_byte = b;
                res.meta_last = (payload_left == 32'd1);
                made = 1'b1;
                payload_left = payload_left - 32'd1;
                if (payload_left == 0) begin
                    parse_phase = mtep_pkg::PH_DELAY;
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic int idle_gap();
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (pick < 70) begin
            return 0;
        end
        if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        if (pick < 99) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic push_byte(input mtep_pkg::in_item_t it, input logic hand_checked,
                             input mtep_pkg::out_item_t hand_result);
        int                  gap;
        bit                  made;
        mtep_pkg::out_item_t res;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (parse_phase != mtep_pkg::PH_DONE || it.new_track) begin
            live_bytes++;
        end
        parse_track_byte(it, made, res);
        if (hand_checked) begin
            predicted_events.push_back(hand_result);
        end else if (made) begin
            predicted_events.push_back(res);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (predicted_events.size() != 0);
    endtask

    task automatic add_byte(input logic [7:0] b);
        event_bytes.push_back('{track_byte: b, new_track: 1'b0});
    endtask

    task automatic add_length_and_payload();
        int len;
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
            add_byte(8'h80);
        end
        add_byte(8'(len));
        repeat (len) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_event(input bit fresh_track, output bit ends_track);
        int         pick;
        int         groups;
        logic [7:0] st;
        logic [7:0] meta_type;
        ends_track = 1'b0;
        groups = ($urandom_range(0, 99) < 80) ? 1 : $urandom_range(2, 5);
        repeat (groups - 1) add_byte(8'($urandom_range(8'h80, 8'hFF)));
        add_byte(8'($urandom_range(0, 8'h7F)));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            add_byte(mtep_pkg::ST_META);
            add_byte(mtep_pkg::META_END_TRACK);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            ends_track = 1'b1;
        end else if (pick < 28) begin
            st = fresh_track ? 8'h00 : running_st;
            add_byte(8'($urandom_range(0, 8'h7F)));
            if (data_bytes_for(st) == 2) begin
                add_byte(8'($urandom_range(0, 8'h7F)));
            end
        end else begin
            if (pick < 73) begin
                st = 8'($urandom_range(8'h80, 8'hEF));
            end else if (pick < 88) begin
                st = mtep_pkg::ST_META;
            end else begin
                st = 8'($urandom_range(mtep_pkg::ST_SYSTEM, 8'hFE));
            end
            add_byte(st);
            if (st == mtep_pkg::ST_META) begin
                do meta_type = 8'($urandom_range(0, 8'h7F));
                while (meta_type == mtep_pkg::META_END_TRACK);
                add_byte(meta_type);
            end else begin
                repeat (data_bytes_for(st)) add_byte(8'($urandom_range(0, 8'h7F)));
            end
            if (takes_length(st)) begin
                add_length_and_payload();
            end
        end
        if (fresh_track) begin
            event_bytes[0].new_track = 1'b1;
        end
    endtask

    task automatic compare_result(input mtep_pkg::out_item_t want,
                                  input mtep_pkg::out_item_t got);
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatch_count++;
        end
        if (got.delay !== want.delay) begin
            $error("delay: expected %0h, actual %0h", want.delay, got.delay);
            mismatch_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0h, actual %0h", want.status, got.status);
            mismatch_count++;
        end
        if (got.data_first !== want.data_first) begin
            $error("data_first: expected %0h, actual %0h", want.data_first, got.data_first);
            mismatch_count++;
        end
        if (got.data_second !== want.data_second) begin
            $error("data_second: expected %0h, actual %0h", want.data_second, got.data_second);
            mismatch_count++;
        end
        if (got.meta_length !== want.meta_length) begin
            $error("meta_length: expected %0h, actual %0h", want.meta_length, got.meta_length);
            mismatch_count++;
        end
        if (got.meta_byte !== want.meta_byte) begin
            $error("meta_byte: expected %0h, actual %0h", want.meta_byte, got.meta_byte);
            mismatch_count++;
        end
        if (got.meta_last !== want.meta_last) begin
            $error("meta_last: expected %0b, actual %0b", want.meta_last, got.meta_last);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        int pick;
        if (ready_hold == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(50, 200);
            end else if (pick < 65) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(1, 8);
            end else if (pick < 95) begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end else begin
            ready_hold--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_events.size() == 0) begin
                    $error("unexpected result transaction: kind %0d status %0h",
                           m_item.kind, m_item.status);
                    mismatch_count++;
                end else begin
                    compare_result(predicted_events.pop_front(), m_item);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("midi_track_event_parser test failed");
                $finish;
            end
        end
    end

    initial begin
        bit fresh_track;
        bit ends_track;
        bit drained_midway;
        fresh_track    = 1'b0;
        drained_midway = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            push_byte('{track_byte: DIRECTED_ROWS[i].track_byte,
                        new_track: DIRECTED_ROWS[i].new_track},
                      DIRECTED_ROWS[i].hand_checked, DIRECTED_ROWS[i].hand_result);
        end

        while (live_bytes < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 5) begin
                repeat ($urandom_range(1, 6)) begin
                    event_bytes.push_back('{track_byte: 8'($urandom_range(0, 255)),
                                            new_track: ($urandom_range(0, 7) == 0)});
                end
            end else begin
                if ($urandom_range(0, 99) < 3) begin
                    fresh_track = 1'b1;
                end
                build_event(fresh_track, ends_track);
                fresh_track = ends_track;
            end
            foreach (event_bytes[i]) begin
                push_byte(event_bytes[i], 1'b0, NO_RESULT);
            end
            event_bytes.delete();
            if ((!drained_midway && live_bytes >= ITEM_TARGET / 2)
                    || $urandom_range(0, 99) == 0) begin
                drained_midway = 1'b1;
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("midi_track_event_parser test passed");
        end else begin
            $display("midi_track_event_parser test failed");
        end
        $finish;
    end

endmodule
